// ===== rtl/core/crtb_pkg.sv =====
// Shared types and constants for the cascaded reload timer bank.
// Depends on nothing; imported by the timer cell, the top level and the checker.
`timescale 1ns / 1ps

package crtb_pkg;

  // Field widths fixed by the bus format.
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned CH_W     = 2;
  localparam int unsigned DATA_W   = 16;
  localparam int unsigned FLAG_W   = 4;
  localparam int unsigned PSC_W    = 10;
  localparam int unsigned SEL_W    = 2;
  localparam int unsigned IN_USER_W  = REQ_W + CH_W;
  localparam int unsigned OUT_DATA_W = DATA_W + 2 * FLAG_W;

  // Control word bit positions.
  localparam int unsigned CTL_CASCADE_BIT = 2;
  localparam int unsigned CTL_IRQ_BIT     = 6;
  localparam int unsigned CTL_ENABLE_BIT  = 7;

  localparam logic [DATA_W-1:0] COUNT_MAX = 16'hFFFF;

  // Bus request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_TICK        = 3'd0,
    REQ_WR_RELOAD   = 3'd1,
    REQ_WR_CONTROL  = 3'd2,
    REQ_RD_COUNTER  = 3'd3,
    REQ_RD_CONTROL  = 3'd4
  } crtb_req_t;

  // Broadcast from the decoder to every cell.
  typedef struct packed {
    logic              tick;
    logic              wr_reload;
    logic              wr_control;
    logic [DATA_W-1:0] wdata;
  } crtb_cell_ctrl_t;

  // Status a cell shows to the decoder and to its neighbor.
  typedef struct packed {
    logic              ovf;
    logic              irq;
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] ctrl_word;
  } crtb_cell_stat_t;

  // Last prescaler count before the timer advances: divisor minus one.
  function automatic logic [PSC_W-1:0] prescale_limit(input logic [SEL_W-1:0] sel);
    logic [PSC_W-1:0] lim;
    case (sel)
      2'd1:    lim = 10'd63;
      2'd2:    lim = 10'd255;
      2'd3:    lim = 10'd1023;
      default: lim = 10'd0;
    endcase
    return lim;
  endfunction

endpackage

// ===== rtl/core/crtb_cell.sv =====
// One 16-bit reload timer of the bank with its prescaler and control bits.
// Depends on crtb_pkg; the top level chains cells through the overflow signal.
`timescale 1ns / 1ps

module crtb_cell
  import crtb_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  crtb_cell_ctrl_t ctrl,
  input  logic            addr_hit,
  input  logic            cascade_in,
  output crtb_cell_stat_t stat
);

  logic [DATA_W-1:0] count_r, count_nxt;
  logic [DATA_W-1:0] reload_r, reload_nxt;
  logic [SEL_W-1:0]  psel_r, psel_nxt;
  logic              cascade_r, cascade_nxt;
  logic              irq_en_r, irq_en_nxt;
  logic              run_r, run_nxt;
  logic [PSC_W-1:0]  psc_r, psc_nxt;

  logic [PSC_W-1:0]  psc_lim;
  logic              psc_hit;
  logic              inc;
  logic              ovf;

  // Decide whether this tick advances the counter.
  always_comb begin
    psc_lim = prescale_limit(psel_r);
    psc_hit = (psc_r >= psc_lim);
    inc     = 1'b0;
    psc_nxt = psc_r;
    if (ctrl.tick && run_r) begin
      if (cascade_r) begin
        inc = cascade_in;
      end else if (psel_r == '0) begin
        inc = 1'b1;
      end else if (psc_hit) begin
        inc     = 1'b1;
        psc_nxt = '0;
      end else begin
        psc_nxt = psc_r + 1'b1;
      end
    end
    ovf = inc && (count_r == COUNT_MAX);
  end

  // Counter, reload and control register updates.
  always_comb begin
    count_nxt   = count_r;
    reload_nxt  = reload_r;
    psel_nxt    = psel_r;
    cascade_nxt = cascade_r;
    irq_en_nxt  = irq_en_r;
    run_nxt     = run_r;
    if (inc) begin
      count_nxt = ovf ? reload_r : count_r + 1'b1;
    end
    if (ctrl.wr_reload && addr_hit) begin
      reload_nxt = ctrl.wdata;
    end
    if (ctrl.wr_control && addr_hit) begin
      psel_nxt    = ctrl.wdata[SEL_W-1:0];
      cascade_nxt = ctrl.wdata[CTL_CASCADE_BIT];
      irq_en_nxt  = ctrl.wdata[CTL_IRQ_BIT];
      run_nxt     = ctrl.wdata[CTL_ENABLE_BIT];
      // Starting a stopped timer loads it from the reload value.
      if (ctrl.wdata[CTL_ENABLE_BIT] && !run_r) begin
        count_nxt = reload_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      reload_r  <= '0;
      psel_r    <= '0;
      cascade_r <= 1'b0;
      irq_en_r  <= 1'b0;
      run_r     <= 1'b0;
      psc_r     <= '0;
    end else begin
      count_r   <= count_nxt;
      reload_r  <= reload_nxt;
      psel_r    <= psel_nxt;
      cascade_r <= cascade_nxt;
      irq_en_r  <= irq_en_nxt;
      run_r     <= run_nxt;
      psc_r     <= psc_nxt;
    end
  end

  // Status toward the decoder and the next cell.
  always_comb begin
    stat.ovf       = ovf;
    stat.irq       = ovf && irq_en_r;
    stat.count     = count_r;
    stat.ctrl_word = '0;
    stat.ctrl_word[SEL_W-1:0]       = psel_r;
    stat.ctrl_word[CTL_CASCADE_BIT] = cascade_r;
    stat.ctrl_word[CTL_IRQ_BIT]     = irq_en_r;
    stat.ctrl_word[CTL_ENABLE_BIT]  = run_r;
  end

endmodule

// ===== rtl/core/cascaded_reload_timer_bank.sv =====
// Bank of chained 16-bit reload timers behind a streaming request channel.
// A result is registered and appears in the cycle after its request transfer.
// Throughput: one request per cycle while no result is stalled; overflow ripples through the cell chain within it.
// The output register frees up whenever its result transfers, so a stalled result blocks input.
// Reset (rst_n low, synchronous) clears every timer register and empties the output register.
// Depends on crtb_pkg and crtb_cell.
`timescale 1ns / 1ps

module cascaded_reload_timer_bank
  import crtb_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_W-1:0]     in_tdata,   // wdata[15:0]
  input  logic [IN_USER_W-1:0]  in_tuser,   // req_type[2:0], channel[4:3]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // rdata[15:0], overflow_flags[19:16], irq_flags[23:20]
);

  crtb_req_t         req;
  logic [CH_W-1:0]   chan;
  logic              in_xfer;
  crtb_cell_ctrl_t   ctrl;
  crtb_cell_stat_t   stat [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] hit;
  logic [NUM_TIMERS-1:0] casc;

  logic [DATA_W-1:0] rdata;
  logic [FLAG_W-1:0] ovf_flags;
  logic [FLAG_W-1:0] irq_flags;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  assign req       = crtb_req_t'(in_tuser[REQ_W-1:0]);
  assign chan      = in_tuser[IN_USER_W-1:REQ_W];
  assign in_tready = rst_n && (!out_valid_r || out_tready);
  assign in_xfer   = in_tvalid && in_tready;

  // Request decode broadcast to all cells.
  always_comb begin
    ctrl.tick       = 1'b0;
    ctrl.wr_reload  = 1'b0;
    ctrl.wr_control = 1'b0;
    ctrl.wdata      = in_tdata;
    if (in_xfer) begin
      case (req)
        REQ_TICK:       ctrl.tick       = 1'b1;
        REQ_WR_RELOAD:  ctrl.wr_reload  = 1'b1;
        REQ_WR_CONTROL: ctrl.wr_control = 1'b1;
        default:        ;
      endcase
    end
  end

  // Timer chain: each cell sees the overflow of the one before it.
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    assign hit[i] = (32'(chan) == i);
    if (i == 0) begin : g_head
      assign casc[i] = 1'b0;
    end else begin : g_link
      assign casc[i] = stat[i-1].ovf;
    end
    crtb_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .addr_hit   (hit[i]),
      .cascade_in (casc[i]),
      .stat       (stat[i])
    );
  end

  // Flag fields carry only the first timers of the bank.
  for (genvar i = 0; i < FLAG_W; i++) begin : g_flag
    if (i < NUM_TIMERS) begin : g_live
      assign ovf_flags[i] = stat[i].ovf;
      assign irq_flags[i] = stat[i].irq;
    end else begin : g_none
      assign ovf_flags[i] = 1'b0;
      assign irq_flags[i] = 1'b0;
    end
  end

  // Read data: AND-OR select over the addressed cell.
  always_comb begin
    rdata = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (hit[i]) begin
        if (req == REQ_RD_COUNTER) begin
          rdata = rdata | stat[i].count;
        end else if (req == REQ_RD_CONTROL) begin
          rdata = rdata | stat[i].ctrl_word;
        end
      end
    end
  end

  // Output register; loads on each request transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {irq_flags, ovf_flags, rdata};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/core/crtb_checker.sv =====
// Port-level checks for the cascaded reload timer bank, bound to its top level.
// Depends on crtb_pkg and on the port list of cascaded_reload_timer_bank.
`timescale 1ns / 1ps

module crtb_checker
  import crtb_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_USER_W-1:0]  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic in_xfer;
  assign in_xfer = in_tvalid && in_tready;

  // A stalled result holds until it transfers.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or vanished");

  // Requests other than a tick report no overflow or interrupt flags.
  a_flags_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_tuser[REQ_W-1:0] != REQ_TICK) |=> out_tdata[OUT_DATA_W-1:DATA_W] == '0)
    else $error("flags set on a request that is not a tick");

  // Writes and ticks return zero read data.
  a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_tuser[REQ_W-1:0] == REQ_TICK || in_tuser[REQ_W-1:0] == REQ_WR_RELOAD ||
                in_tuser[REQ_W-1:0] == REQ_WR_CONTROL) |=> out_tdata[DATA_W-1:0] == '0)
    else $error("read data nonzero on a request that is not a read");

  // An interrupt bit only accompanies an overflow of the same timer.
  a_irq_subset: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_DATA_W-1:DATA_W+FLAG_W] &
                    ~out_tdata[DATA_W+FLAG_W-1:DATA_W]) == '0)
    else $error("interrupt flag without overflow");

endmodule

bind cascaded_reload_timer_bank crtb_checker u_crtb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== sim/cascaded_reload_timer_bank_test.sv =====
// Self-checking testbench for the cascaded reload timer bank: directed, prescaler and random tests.
// Results are predicted per request transfer and compared in order; depends on crtb_pkg and the RTL.
`timescale 1ns / 1ps

module cascaded_reload_timer_bank_test;
  import crtb_pkg::*;

  localparam int unsigned TIMER_COUNT = 4;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned REPORT_CAP  = 100;

  // Request codes that the block must treat as no-ops.
  localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = 3'd7;

  // Prescale select codes.
  localparam logic [SEL_W-1:0] PSC_DIV1    = 2'd0;
  localparam logic [SEL_W-1:0] PSC_DIV64   = 2'd1;
  localparam logic [SEL_W-1:0] PSC_DIV256  = 2'd2;
  localparam logic [SEL_W-1:0] PSC_DIV1024 = 2'd3;

  // Control word bits.
  localparam logic [DATA_W-1:0] CTL_CASCADE = 16'd1 << CTL_CASCADE_BIT;
  localparam logic [DATA_W-1:0] CTL_IRQ     = 16'd1 << CTL_IRQ_BIT;
  localparam logic [DATA_W-1:0] CTL_ENABLE  = 16'd1 << CTL_ENABLE_BIT;

  // Result layout, highest field first: irq_flags, overflow_flags, rdata.
  typedef struct packed {
    logic [FLAG_W-1:0] irq_flags;
    logic [FLAG_W-1:0] overflow_flags;
    logic [DATA_W-1:0] rdata;
  } timer_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [DATA_W-1:0]     in_tdata   = '0;  // wdata[15:0]
  logic [IN_USER_W-1:0]  in_tuser   = '0;  // req_type[2:0], channel[4:3]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // rdata[15:0], overflow_flags[19:16], irq_flags[23:20]

  // Shadow copy of every timer register.
  logic [DATA_W-1:0] tmr_count  [TIMER_COUNT];
  logic [DATA_W-1:0] tmr_reload [TIMER_COUNT];
  logic [SEL_W-1:0]  tmr_psel   [TIMER_COUNT];
  logic              tmr_casc   [TIMER_COUNT];
  logic              tmr_irqen  [TIMER_COUNT];
  logic              tmr_run    [TIMER_COUNT];
  logic [PSC_W-1:0]  tmr_psc    [TIMER_COUNT];

  timer_result_t pending_results[$];
  timer_result_t got_result;
  timer_result_t want_result;

  int unsigned error_count  = 0;
  int unsigned cycle_count  = 0;
  bit          no_idle      = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned stall_left   = 0;

  cascaded_reload_timer_bank uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // Last prescaler count before a timer advances.
  function automatic logic [PSC_W-1:0] divider_top(input logic [SEL_W-1:0] sel);
    case (sel)
      PSC_DIV64:   return 10'd63;
      PSC_DIV256:  return 10'd255;
      PSC_DIV1024: return 10'd1023;
      default:     return 10'd0;
    endcase
  endfunction

  // Applies one request to the shadow registers and returns the result it yields.
  task automatic predict_request(input logic [REQ_W-1:0] req, input logic [CH_W-1:0] ch,
                                 input logic [DATA_W-1:0] wd, output timer_result_t res);
    logic carry;
    logic advance;
    logic wrapped;
    res   = '0;
    carry = 1'b0;
    case (req)
      REQ_TICK: begin
        for (int t = 0; t < TIMER_COUNT; t++) begin
          advance = 1'b0;
          wrapped = 1'b0;
          if (tmr_run[t]) begin
            if (tmr_casc[t]) begin
              advance = (t > 0) && carry;
            end else if (tmr_psel[t] == PSC_DIV1) begin
              advance = 1'b1;
            end else if (tmr_psc[t] >= divider_top(tmr_psel[t])) begin
              tmr_psc[t] = '0;
              advance    = 1'b1;
            end else begin
              tmr_psc[t] = tmr_psc[t] + 1'b1;
            end
          end
          if (advance) begin
            if (tmr_count[t] == COUNT_MAX) begin
              tmr_count[t] = tmr_reload[t];
              wrapped      = 1'b1;
            end else begin
              tmr_count[t] = tmr_count[t] + 1'b1;
            end
          end
          if (wrapped) begin
            res.overflow_flags[t] = 1'b1;
            res.irq_flags[t]      = tmr_irqen[t];
          end
          carry = wrapped;
        end
      end
      REQ_WR_RELOAD: tmr_reload[ch] = wd;
      REQ_WR_CONTROL: begin
        tmr_psel[ch]  = wd[SEL_W-1:0];
        tmr_casc[ch]  = wd[CTL_CASCADE_BIT];
        tmr_irqen[ch] = wd[CTL_IRQ_BIT];
        // Only a stopped-to-running transition reloads the counter.
        if (wd[CTL_ENABLE_BIT] && !tmr_run[ch]) tmr_count[ch] = tmr_reload[ch];
        tmr_run[ch]   = wd[CTL_ENABLE_BIT];
      end
      REQ_RD_COUNTER: res.rdata = tmr_count[ch];
      REQ_RD_CONTROL: begin
        res.rdata[SEL_W-1:0]      = tmr_psel[ch];
        res.rdata[CTL_CASCADE_BIT] = tmr_casc[ch];
        res.rdata[CTL_IRQ_BIT]     = tmr_irqen[ch];
        res.rdata[CTL_ENABLE_BIT]  = tmr_run[ch];
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    error_count++;
    if (error_count <= REPORT_CAP)
      $display("[%0t] mismatch in %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  // Offers one request, waits for its transfer and records the expected result.
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [CH_W-1:0] ch,
                              input logic [DATA_W-1:0] wd);
    timer_result_t res;
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {ch, req};
    in_tdata  <= wd;
    do @(posedge clk); while (!in_tready);
    predict_request(req, ch, wd, res);
    pending_results.push_back(res);
  endtask

  // Stops offering and waits until every expected result has transferred.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Mostly ticks and well-formed register accesses, with reload values biased near the top.
  task automatic send_random_request();
    logic [REQ_W-1:0]  req;
    logic [CH_W-1:0]   ch;
    logic [DATA_W-1:0] wd;
    int unsigned       roll;
    roll = $urandom_range(0, 99);
    ch   = CH_W'($urandom_range(0, TIMER_COUNT - 1));
    wd   = DATA_W'($urandom);
    if (roll < 55) begin
      req = REQ_TICK;
    end else if (roll < 65) begin
      req = REQ_WR_RELOAD;
      if ($urandom_range(0, 1) == 0) wd = 16'hFFF0 | 16'($urandom_range(0, 15));
    end else if (roll < 77) begin
      req = REQ_WR_CONTROL;
      // Keep most timers running, and favor the undivided clock so overflows come often.
      if ($urandom_range(0, 9) < 7) wd = wd | CTL_ENABLE;
      if ($urandom_range(0, 1) == 0) wd[SEL_W-1:0] = PSC_DIV1;
    end else if (roll < 86) begin
      req = REQ_RD_COUNTER;
    end else if (roll < 94) begin
      req = REQ_RD_CONTROL;
    end else begin
      req = REQ_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
    end
    send_request(req, ch, wd);
  endtask

  // Reset values, ripple through the chain, special control cases and spare codes.
  task automatic test_directed_cases();
    send_request(REQ_RD_COUNTER, 2'd0, 16'h0000);
    send_request(REQ_RD_CONTROL, 2'd3, 16'hFFFF);
    send_request(REQ_WR_RELOAD, 2'd0, 16'hFFFF);
    send_request(REQ_WR_CONTROL, 2'd0, CTL_ENABLE | CTL_IRQ);
    send_request(REQ_TICK, 2'd0, 16'h0000);
    // Overflow of timer zero must ripple into the cascade timer on the same tick.
    send_request(REQ_WR_RELOAD, 2'd1, 16'hFFFF);
    send_request(REQ_WR_CONTROL, 2'd1, CTL_ENABLE | CTL_IRQ | CTL_CASCADE);
    send_request(REQ_TICK, 2'd3, 16'hFFFF);
    send_request(REQ_RD_CONTROL, 2'd1, 16'h0000);
    // Unused control bits are ignored; a running timer is not reloaded.
    send_request(REQ_WR_CONTROL, 2'd1, 16'hFF3F);
    send_request(REQ_RD_CONTROL, 2'd1, 16'h0000);
    // A cascade timer in position zero has no predecessor and stays put.
    send_request(REQ_WR_CONTROL, 2'd0, CTL_ENABLE | CTL_CASCADE);
    send_request(REQ_TICK, 2'd2, 16'h0000);
    send_request(REQ_RD_COUNTER, 2'd0, 16'h0000);
    // A stopped timer neither counts nor advances its prescaler.
    send_request(REQ_WR_CONTROL, 2'd2, {14'd0, PSC_DIV1024});
    send_request(REQ_TICK, 2'd0, 16'h0000);
    send_request(REQ_RD_COUNTER, 2'd2, 16'h0000);
    for (int code = REQ_SPARE_FIRST; code <= REQ_SPARE_LAST; code++)
      send_request(REQ_W'(code), 2'd3, 16'hFFFF);
    send_request(REQ_RD_COUNTER, 2'd1, 16'h0000);
    send_request(REQ_RD_COUNTER, 2'd3, 16'h0000);
    send_request(REQ_WR_CONTROL, 2'd0, 16'h0000);
    send_request(REQ_WR_CONTROL, 2'd1, 16'h0000);
    drain_results();
  endtask

  // Runs the 64 and 256 dividers to overflow while the 1024 divider builds up a large
  // count, then changes a select mid-count.
  task automatic test_prescaler_divide();
    send_request(REQ_WR_RELOAD, 2'd0, 16'hFFFC);
    send_request(REQ_WR_CONTROL, 2'd0, CTL_ENABLE | CTL_IRQ | PSC_DIV64);
    send_request(REQ_WR_RELOAD, 2'd1, 16'hFFFE);
    send_request(REQ_WR_CONTROL, 2'd1, CTL_ENABLE | PSC_DIV256);
    send_request(REQ_WR_RELOAD, 2'd2, 16'hFFFF);
    send_request(REQ_WR_CONTROL, 2'd2, CTL_ENABLE | CTL_IRQ | PSC_DIV1024);
    send_request(REQ_WR_RELOAD, 2'd3, 16'hFFFE);
    send_request(REQ_WR_CONTROL, 2'd3, CTL_ENABLE | CTL_IRQ | CTL_CASCADE);
    for (int n = 0; n < 520; n++) begin
      send_request(REQ_TICK, CH_W'(n), 16'($urandom));
      if (n % 100 == 99) send_request(REQ_RD_COUNTER, CH_W'(n / 100), 16'h0000);
    end
    // The held count is past the new divider, so the next tick advances the timer.
    send_request(REQ_WR_CONTROL, 2'd2, CTL_ENABLE | PSC_DIV64);
    repeat (3) send_request(REQ_TICK, 2'd0, 16'h0000);
    send_request(REQ_RD_COUNTER, 2'd2, 16'h0000);
    for (int t = 0; t < TIMER_COUNT; t++) send_request(REQ_WR_CONTROL, CH_W'(t), 16'h0000);
    drain_results();
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_output_backpressure();
    no_idle      = 1'b1;
    hold_request = 1'b1;
    repeat (30) send_random_request();
    no_idle = 1'b0;
    drain_results();
  endtask

  task automatic test_random_traffic();
    repeat (200) send_random_request();
    drain_results();
  endtask

  // Closing stretch with neither side idling.
  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (150) send_random_request();
    drain_results();
  endtask

  // Result side: checks each transfer and drives ready with random stalls.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_result = out_tdata;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 32'd0, 32'(got_result));
        end else begin
          want_result = pending_results.pop_front();
          if (got_result.rdata !== want_result.rdata)
            report_mismatch("rdata", 32'(want_result.rdata), 32'(got_result.rdata));
          if (got_result.overflow_flags !== want_result.overflow_flags)
            report_mismatch("overflow_flags", 32'(want_result.overflow_flags),
                            32'(got_result.overflow_flags));
          if (got_result.irq_flags !== want_result.irq_flags)
            report_mismatch("irq_flags", 32'(want_result.irq_flags),
                            32'(got_result.irq_flags));
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    for (int t = 0; t < TIMER_COUNT; t++) begin
      tmr_count[t]  = '0;
      tmr_reload[t] = '0;
      tmr_psel[t]   = '0;
      tmr_casc[t]   = 1'b0;
      tmr_irqen[t]  = 1'b0;
      tmr_run[t]    = 1'b0;
      tmr_psc[t]    = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_prescaler_divide();
    test_output_backpressure();
    test_random_traffic();
    test_back_to_back();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== cascaded_reload_timer_bank.f =====
rtl/core/crtb_pkg.sv
rtl/core/crtb_cell.sv
rtl/core/cascaded_reload_timer_bank.sv
rtl/core/crtb_checker.sv
sim/cascaded_reload_timer_bank_test.sv
